// ===== src/mmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmp_pkg: shared types and codes for the minibatch matrix product block
// Operation codes, configuration register indexes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mmp_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_LOAD_IN  = 2'd0,
        OP_LOAD_OUT = 2'd1,
        OP_LOAD_COR = 2'd2,
        OP_COMPUTE  = 2'd3
    } t_op;

    // Product modes
    typedef enum logic [1:0] {
        MODE_SCORE   = 2'd0,
        MODE_OUT_UPD = 2'd1,
        MODE_IN_UPD  = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_HIDDEN = 2'd1,
        CFG_ROWS   = 2'd2,
        CFG_COLS   = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 7;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Field widths
    localparam int VAL_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W = 48;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic run_done;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

// ===== src/mmp_in_if.sv =====
// ----------------------------------------------------------------------------
// mmp_in_if: request channel
// Valid/ready channel carrying one load or compute request per beat.
// ----------------------------------------------------------------------------
interface mmp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [3:0]         first_index;
    logic [5:0]         second_index;
    logic signed [15:0] load_value;

    modport source (output valid, output operation, output first_index,
                    output second_index, output load_value, input ready);
    modport sink   (input valid, input operation, input first_index,
                    input second_index, input load_value, output ready);
endinterface

// ===== src/mmp_out_if.sv =====
// ----------------------------------------------------------------------------
// mmp_out_if: result channel
// Valid/ready channel carrying one compute result per beat.
// ----------------------------------------------------------------------------
interface mmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] result_value;
    logic               status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== src/minibatch_matrix_products.sv =====
// ----------------------------------------------------------------------------
// minibatch_matrix_products: fixed-point minibatch matrix product engine
// Stores input-layer vectors, output-layer vectors and a correction matrix and
// returns one Q24.24 element of the product selected by the mode register.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests. Loads (operations 0..2) write one memory entry
//   when the indexes fit the storage and return nothing. A compute request
//   (operation 3) returns one beat on o_out: result_value and status (1 =
//   index out of range or mode 3). A compute runs N products through the
//   single multiply-accumulate pipeline (memory read, multiply, add), with
//   N = hidden_size (mode 0), row_count (mode 1) or col_count (mode 2) and
//   N zero on an error; the pipeline does one product per cycle and, once
//   drained, the result goes to the output register. No request is accepted
//   while a compute is running; the next one is taken the cycle after the
//   result is written. Loads are taken one per cycle while no compute runs.
//   A finished result waits in the output register; loads keep being accepted
//   meanwhile, and a following compute runs and holds its result until the
//   receiver takes the earlier one.
//   Reset (i_rst_n low, synchronous) loads the mode and size registers with their
//   defaults and empties the pipeline; memory contents are undefined until
//   loaded. Configuration writes on i_cfg_* belong only where no compute is
//   in flight.
// ----------------------------------------------------------------------------
module minibatch_matrix_products #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int MAX_HIDDEN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  mmp_pkg::t_cfg_idx  i_cfg_idx,
    input  mmp_pkg::t_cfg_data i_cfg_data,
    mmp_in_if.sink             i_in,
    mmp_out_if.source          o_out
);
    import mmp_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    is_compute;

    assign is_compute = (i_in.operation == OP_COMPUTE);

    // Sequencer
    mmp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_is_compute (is_compute),
        .o_in_ready   (i_in.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // Storage and arithmetic
    mmp_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_HIDDEN (MAX_HIDDEN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_in.operation),
        .i_first_index  (i_in.first_index),
        .i_second_index (i_in.second_index),
        .i_load_value   (i_in.load_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_out_status   (o_out.status)
    );

endmodule

// ===== src/mmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmp_ctrl: request sequencer
// Accepts requests, runs the multiply-accumulate loop for a compute request,
// waits for the pipeline to empty and the output register to be free and hands the result to it.
// ----------------------------------------------------------------------------
module mmp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_is_compute,
    output logic             o_in_ready,
    input  mmp_pkg::t_status i_status,
    output mmp_pkg::t_cmd    o_cmd
);
    import mmp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_is_compute) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RUN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_RUN: begin
                if (i_status.run_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DRAIN: begin
                // last product lands in the accumulator, then the result moves out
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/mmp_datapath.sv =====
// ----------------------------------------------------------------------------
// mmp_datapath: storage, configuration and multiply-accumulate pipeline
// Holds the three vector/matrix memories, the size registers, the address
// walkers, a registered multiplier, the accumulator and the result register.
// ----------------------------------------------------------------------------
module mmp_datapath #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int MAX_HIDDEN = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  mmp_pkg::t_cfg_idx      i_cfg_idx,
    input  mmp_pkg::t_cfg_data     i_cfg_data,
    // request payload
    input  logic [1:0]             i_operation,
    input  logic [3:0]             i_first_index,
    input  logic [5:0]             i_second_index,
    input  logic signed [15:0]     i_load_value,
    // control
    input  mmp_pkg::t_cmd          i_cmd,
    output mmp_pkg::t_status       o_status,
    // result
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic signed [47:0]     o_result_value,
    output logic                   o_out_status
);
    import mmp_pkg::*;

    localparam int IN_DEPTH  = MAX_ROWS * MAX_HIDDEN;
    localparam int OUT_DEPTH = MAX_COLS * MAX_HIDDEN;
    localparam int COR_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int IN_AW  = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int OUT_AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int COR_AW = (COR_DEPTH > 1) ? $clog2(COR_DEPTH) : 1;
    localparam int KMAX_RC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int KMAX = (KMAX_RC > MAX_HIDDEN) ? KMAX_RC : MAX_HIDDEN;
    localparam int KW = $clog2(KMAX + 1);

    // Configuration registers
    logic [1:0] r_mode;
    logic [6:0] r_hidden;
    logic [4:0] r_rows;
    logic [4:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SCORE;
            r_hidden <= 7'd64;
            r_rows   <= 5'd16;
            r_cols   <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_HIDDEN: r_hidden <= i_cfg_data[6:0];
                CFG_ROWS:   r_rows   <= i_cfg_data[4:0];
                CFG_COLS:   r_cols   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sizes in use, limited to the storage
    logic [KW-1:0] nr;
    logic [KW-1:0] nc;
    logic [KW-1:0] nh;

    assign nr = (32'(r_rows) > MAX_ROWS) ? KW'(MAX_ROWS) : KW'(r_rows);
    assign nc = (32'(r_cols) > MAX_COLS) ? KW'(MAX_COLS) : KW'(r_cols);
    assign nh = (32'(r_hidden) > MAX_HIDDEN) ? KW'(MAX_HIDDEN) : KW'(r_hidden);

    // Load decode: checked against storage, not the sizes
    logic in_we;
    logic out_we;
    logic cor_we;
    logic [IN_AW-1:0]  in_wa;
    logic [OUT_AW-1:0] out_wa;
    logic [COR_AW-1:0] cor_wa;

    assign in_we  = i_cmd.load && (i_operation == OP_LOAD_IN)
                 && (32'(i_first_index) < MAX_ROWS) && (32'(i_second_index) < MAX_HIDDEN);
    assign out_we = i_cmd.load && (i_operation == OP_LOAD_OUT)
                 && (32'(i_first_index) < MAX_COLS) && (32'(i_second_index) < MAX_HIDDEN);
    assign cor_we = i_cmd.load && (i_operation == OP_LOAD_COR)
                 && (32'(i_first_index) < MAX_ROWS) && (32'(i_second_index) < MAX_COLS);
    assign in_wa  = IN_AW'(int'(i_first_index) * MAX_HIDDEN + int'(i_second_index));
    assign out_wa = OUT_AW'(int'(i_first_index) * MAX_HIDDEN + int'(i_second_index));
    assign cor_wa = COR_AW'(int'(i_first_index) * MAX_COLS + int'(i_second_index));

    // Address walkers and trip count
    logic [IN_AW-1:0]  r_in_addr,  r_in_stride;
    logic [OUT_AW-1:0] r_out_addr, r_out_stride;
    logic [COR_AW-1:0] r_cor_addr, r_cor_stride;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_len;
    logic              r_ok;

    logic              st_ok;
    logic [KW-1:0]     st_len;

    // Range check and trip count for the current mode
    always_comb begin
        st_ok  = 1'b0;
        st_len = '0;
        case (r_mode)
            MODE_SCORE: begin
                st_ok  = (32'(i_first_index) < 32'(nr)) && (32'(i_second_index) < 32'(nc));
                st_len = nh;
            end
            MODE_OUT_UPD: begin
                st_ok  = (32'(i_first_index) < 32'(nc)) && (32'(i_second_index) < 32'(nh));
                st_len = nr;
            end
            MODE_IN_UPD: begin
                st_ok  = (32'(i_first_index) < 32'(nr)) && (32'(i_second_index) < 32'(nh));
                st_len = nc;
            end
            default: begin
                st_ok  = 1'b0;
                st_len = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ok  <= st_ok;
            r_len <= st_ok ? st_len : '0;
            r_k   <= '0;
            r_in_addr    <= '0;
            r_in_stride  <= '0;
            r_out_addr   <= '0;
            r_out_stride <= '0;
            r_cor_addr   <= '0;
            r_cor_stride <= '0;
            case (r_mode)
                MODE_SCORE: begin
                    r_in_addr    <= IN_AW'(int'(i_first_index) * MAX_HIDDEN);
                    r_in_stride  <= IN_AW'(1);
                    r_out_addr   <= OUT_AW'(int'(i_second_index) * MAX_HIDDEN);
                    r_out_stride <= OUT_AW'(1);
                end
                MODE_OUT_UPD: begin
                    r_cor_addr   <= COR_AW'(i_first_index);
                    r_cor_stride <= COR_AW'(MAX_COLS);
                    r_in_addr    <= IN_AW'(i_second_index);
                    r_in_stride  <= IN_AW'(MAX_HIDDEN);
                end
                MODE_IN_UPD: begin
                    r_cor_addr   <= COR_AW'(int'(i_first_index) * MAX_COLS);
                    r_cor_stride <= COR_AW'(1);
                    r_out_addr   <= OUT_AW'(i_second_index);
                    r_out_stride <= OUT_AW'(MAX_HIDDEN);
                end
                default: ;
            endcase
        end else if (i_cmd.step) begin
            r_k        <= r_k + KW'(1);
            r_in_addr  <= r_in_addr + r_in_stride;
            r_out_addr <= r_out_addr + r_out_stride;
            r_cor_addr <= r_cor_addr + r_cor_stride;
        end
    end

    // Memories: one write and one registered read each
    logic signed [VAL_W-1:0] r_in_mem  [IN_DEPTH];
    logic signed [VAL_W-1:0] r_out_mem [OUT_DEPTH];
    logic signed [VAL_W-1:0] r_cor_mem [COR_DEPTH];
    logic signed [VAL_W-1:0] r_in_rd;
    logic signed [VAL_W-1:0] r_out_rd;
    logic signed [VAL_W-1:0] r_cor_rd;

    always_ff @(posedge i_clk) begin
        if (in_we) begin
            r_in_mem[in_wa] <= i_load_value;
        end
        r_in_rd <= r_in_mem[r_in_addr];
    end

    always_ff @(posedge i_clk) begin
        if (out_we) begin
            r_out_mem[out_wa] <= i_load_value;
        end
        r_out_rd <= r_out_mem[r_out_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cor_we) begin
            r_cor_mem[cor_wa] <= i_load_value;
        end
        r_cor_rd <= r_cor_mem[r_cor_addr];
    end

    // Operand select, multiply, accumulate
    logic signed [VAL_W-1:0]  mul_a;
    logic signed [VAL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1;
    logic                     r_v2;

    assign mul_a = (r_mode == MODE_SCORE) ? r_in_rd : r_cor_rd;
    assign mul_b = (r_mode == MODE_OUT_UPD) ? r_in_rd : r_out_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Result register
    logic r_out_valid;
    logic signed [ACC_W-1:0] r_out_value;
    logic r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value <= r_ok ? r_acc : '0;
            r_out_err   <= !r_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_out_status   = r_out_err;

    assign o_status.run_done  = (r_k == r_len);
    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule
